// ----- src/epoch_seconds_to_calendar_assert.svh -----
// assertion macros for the epoch seconds to calendar converter
// used by the port checker; no other dependencies
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH

// condition now implies expression in the same cycle
`define ESC_ASSERT_NOW(lbl, clk, rstn, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error("converter check failed");

// condition now implies expression in the next cycle
`define ESC_ASSERT_NEXT(lbl, clk, rstn, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error("converter check failed");

`endif

// ----- src/esc_pkg.sv -----
// shared types, constants and helpers of the epoch seconds to calendar converter
// no dependencies
`default_nettype none

package esc_pkg;

    localparam int unsigned SECS_PER_DAY    = 86400;
    localparam int unsigned SECS_PER_HOUR   = 3600;
    localparam int unsigned SECS_PER_MIN    = 60;
    localparam int unsigned LEAP_CYCLE      = 400;
    localparam int unsigned CENTURY         = 100;
    localparam logic [11:0] BASE_YEAR_RESET = 12'd1930;

    // field widths
    localparam int unsigned IN_W    = 32;
    localparam int unsigned DAYS_W  = 16;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned FIELDS_W = DAYS_W + HOUR_W + MIN_W + SEC_W + YEAR_W + MONTH_W
                                     + DAY_W;
    localparam int unsigned OUT_W   = ((FIELDS_W + 7) / 8) * 8;

    // reciprocals for exact division by constants, q = (x * recip) >> shift
    //   days:      (seconds >> 7) / 675, shift 35
    //   hours:     (rest >> 4) / 225, shift 21
    //   minutes:   (rest >> 2) / 15, shift 14
    //   400 years: (year >> 4) / 25, shift 13
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;
    localparam logic [8:0]  CYC_RECIP  = 9'd328;

    // datapath operations
    typedef enum logic [3:0] {
        ESC_OP_NONE,
        ESC_OP_LOAD,
        ESC_OP_DAY,
        ESC_OP_DAY_REM,
        ESC_OP_HOUR,
        ESC_OP_HOUR_REM,
        ESC_OP_MIN,
        ESC_OP_MIN_REM,
        ESC_OP_YEAR,
        ESC_OP_MONTH,
        ESC_OP_CAPTURE
    } esc_op_t;

    // controller to datapath
    typedef struct packed {
        esc_op_t    op;
    } esc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic year_more;
        logic month_more;
    } esc_stat_t;

    // length of month m (1 = january)
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:                       len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- src/esc_ctrl.sv -----
// sequencer of the epoch seconds to calendar converter
// depends on esc_pkg
`default_nettype none

module esc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output esc_pkg::esc_cmd_t     cmd,
    input  wire esc_pkg::esc_stat_t stat
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY,
        ST_DAY_REM,
        ST_HOUR,
        ST_HOUR_REM,
        ST_MIN,
        ST_MIN_REM,
        ST_YEAR,
        ST_MONTH,
        ST_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // next state and command
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd.op         = esc_pkg::ESC_OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op     = esc_pkg::ESC_OP_LOAD;
                    state_next = ST_DAY;
                end
            end
            ST_DAY:
            begin
                cmd.op     = esc_pkg::ESC_OP_DAY;
                state_next = ST_DAY_REM;
            end
            ST_DAY_REM:
            begin
                cmd.op     = esc_pkg::ESC_OP_DAY_REM;
                state_next = ST_HOUR;
            end
            ST_HOUR:
            begin
                cmd.op     = esc_pkg::ESC_OP_HOUR;
                state_next = ST_HOUR_REM;
            end
            ST_HOUR_REM:
            begin
                cmd.op     = esc_pkg::ESC_OP_HOUR_REM;
                state_next = ST_MIN;
            end
            ST_MIN:
            begin
                cmd.op     = esc_pkg::ESC_OP_MIN;
                state_next = ST_MIN_REM;
            end
            ST_MIN_REM:
            begin
                cmd.op     = esc_pkg::ESC_OP_MIN_REM;
                state_next = ST_YEAR;
            end
            ST_YEAR:
            begin
                cmd.op = esc_pkg::ESC_OP_YEAR;
                if (!stat.year_more)
                begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                cmd.op = esc_pkg::ESC_OP_MONTH;
                if (!stat.month_more)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.op         = esc_pkg::ESC_OP_CAPTURE;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/esc_datapath.sv -----
// working registers, step arithmetic and result register of the converter
// depends on esc_pkg
`default_nettype none

module esc_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [esc_pkg::YEAR_W-1:0]  cfg_wr_data,
    input  wire logic [esc_pkg::IN_W-1:0]    s_tdata,
    output logic      [esc_pkg::OUT_W-1:0]   m_tdata,
    input  wire esc_pkg::esc_cmd_t           cmd,
    output esc_pkg::esc_stat_t               stat
);

    logic [11:0] base_year_reg;

    logic [31:0] rem_reg, rem_next;
    logic [15:0] days_reg, days_next;
    logic [4:0]  hour_reg, hour_next;
    logic [5:0]  min_reg, min_next;
    logic [3:0]  cyc_reg, cyc_next;
    logic [11:0] m400_reg, m400_next;
    logic [6:0]  m100_reg, m100_next;
    logic [12:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [15:0] left_reg, left_next;
    logic [esc_pkg::OUT_W-1:0] out_reg, out_next;

    logic [50:0] day_quo_prod;
    logic [31:0] day_rem_prod;
    logic [25:0] hour_quo_prod;
    logic [16:0] hour_rem_prod;
    logic [19:0] min_quo_prod;
    logic [11:0] min_rem_prod;
    logic [16:0] cyc_quo_prod;
    logic [11:0] cyc_rem_prod;
    logic [11:0] hund_sel;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;
    logic [4:0]  day_of_month;

    // quotients by reciprocal multiplication, exact over each operand range
    assign day_quo_prod  = 51'(rem_reg[31:7]) * 51'(esc_pkg::DAY_RECIP);
    assign hour_quo_prod = 26'(rem_reg[16:4]) * 26'(esc_pkg::HOUR_RECIP);
    assign min_quo_prod  = 20'(rem_reg[11:2]) * 20'(esc_pkg::MIN_RECIP);
    assign cyc_quo_prod  = 17'(m400_reg[11:4]) * 17'(esc_pkg::CYC_RECIP);

    // quotient times divisor for the remainders
    assign day_rem_prod  = 32'(days_reg) * 32'(esc_pkg::SECS_PER_DAY);
    assign hour_rem_prod = 17'(hour_reg) * 17'(esc_pkg::SECS_PER_HOUR);
    assign min_rem_prod  = 12'(min_reg) * 12'(esc_pkg::SECS_PER_MIN);
    assign cyc_rem_prod  = 12'(cyc_reg) * 12'(esc_pkg::LEAP_CYCLE);

    // year mod 100 from year mod 400
    always_comb
    begin
        if (m400_reg >= 12'(3 * esc_pkg::CENTURY))
            hund_sel = 12'(3 * esc_pkg::CENTURY);
        else if (m400_reg >= 12'(2 * esc_pkg::CENTURY))
            hund_sel = 12'(2 * esc_pkg::CENTURY);
        else if (m400_reg >= 12'(esc_pkg::CENTURY))
            hund_sel = 12'(esc_pkg::CENTURY);
        else
            hund_sel = 12'd0;
    end

    // leap rule on the walked year
    assign leap = ((year_reg[1:0] == 2'd0) && (m100_reg != 7'd0)) || (m400_reg == 12'd0);
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = esc_pkg::month_len(month_reg, leap);

    assign stat.year_more  = (left_reg >= {7'd0, ylen});
    assign stat.month_more = (left_reg >= {11'd0, mlen});

    assign day_of_month = left_reg[4:0] + 5'd1;

    // step operations
    always_comb
    begin
        rem_next   = rem_reg;
        days_next  = days_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        cyc_next   = cyc_reg;
        m400_next  = m400_reg;
        m100_next  = m100_reg;
        year_next  = year_reg;
        month_next = month_reg;
        left_next  = left_reg;
        out_next   = out_reg;
        case (cmd.op)
            esc_pkg::ESC_OP_LOAD:
            begin
                rem_next   = s_tdata;
                m400_next  = base_year_reg;
                year_next  = {1'b0, base_year_reg};
                month_next = 4'd1;
            end
            esc_pkg::ESC_OP_DAY:
            begin
                days_next = day_quo_prod[50:35];
                cyc_next  = cyc_quo_prod[16:13];
            end
            esc_pkg::ESC_OP_DAY_REM:
            begin
                rem_next  = rem_reg - day_rem_prod;
                m400_next = m400_reg - cyc_rem_prod;
                left_next = days_reg;
            end
            esc_pkg::ESC_OP_HOUR:
            begin
                hour_next = hour_quo_prod[25:21];
                m100_next = 7'(m400_reg - hund_sel);
            end
            esc_pkg::ESC_OP_HOUR_REM:
            begin
                rem_next = rem_reg - {15'd0, hour_rem_prod};
            end
            esc_pkg::ESC_OP_MIN:
            begin
                min_next = min_quo_prod[19:14];
            end
            esc_pkg::ESC_OP_MIN_REM:
            begin
                rem_next = rem_reg - {20'd0, min_rem_prod};
            end
            esc_pkg::ESC_OP_YEAR:
            begin
                if (stat.year_more)
                begin
                    left_next = left_reg - {7'd0, ylen};
                    year_next = year_reg + 13'd1;
                    m400_next = (m400_reg == 12'(esc_pkg::LEAP_CYCLE - 1)) ? 12'd0
                                                                           : m400_reg + 12'd1;
                    m100_next = (m100_reg == 7'(esc_pkg::CENTURY - 1)) ? 7'd0
                                                                       : m100_reg + 7'd1;
                end
            end
            esc_pkg::ESC_OP_MONTH:
            begin
                if (stat.month_more)
                begin
                    left_next  = left_reg - {11'd0, mlen};
                    month_next = month_reg + 4'd1;
                end
            end
            esc_pkg::ESC_OP_CAPTURE:
            begin
                out_next = {{(esc_pkg::OUT_W - esc_pkg::FIELDS_W){1'b0}},
                            day_of_month, month_reg, year_reg[11:0], rem_reg[5:0],
                            min_reg, hour_reg, days_reg};
            end
            default:
            begin
            end
        endcase
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_year_reg <= esc_pkg::BASE_YEAR_RESET;
        end
        else if (cfg_wr_en)
        begin
            base_year_reg <= cfg_wr_data;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        days_reg  <= days_next;
        hour_reg  <= hour_next;
        min_reg   <= min_next;
        cyc_reg   <= cyc_next;
        m400_reg  <= m400_next;
        m100_reg  <= m100_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        left_reg  <= left_next;
        out_reg   <= out_next;
    end

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

// ----- src/epoch_seconds_to_calendar.sv -----
// top level of the epoch seconds to calendar converter
// depends on esc_pkg, esc_ctrl and esc_datapath
//
// usage
//   s_tdata carries one request: seconds since 1 january 00:00:00 of base_year.
//   m_tdata carries the result: whole days, time of day and gregorian date.
//   cfg_wr_en / cfg_wr_data write base_year (12 bits); write only while idle.
// timing
//   one request at a time; s_tready is high only while the sequencer is idle.
//   a request runs through the states day, day_rem, hour, hour_rem, min and
//   min_rem, which split the seconds into days, hour, minute and second by
//   reciprocal multiplies and remainders, then through a year walk over Y whole
//   years (up to 136) and a month walk over M whole months (up to 11); the finish
//   state loads the result register and only then is the next request taken.
// reset and stall
//   rst_n clears the sequencer and the output valid and sets base_year to 1930.
//   the result sits in its own register; a new request is taken while it waits,
//   and a finished conversion waits in the sequencer until that register frees.
`default_nettype none

module epoch_seconds_to_calendar (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [esc_pkg::YEAR_W-1:0]  cfg_wr_data,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // elapsed_seconds[31:0]
    input  wire logic [esc_pkg::IN_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // whole_days[15:0], hour[20:16], minute[26:21], second[32:27],
    // year[44:33], month[48:45], day[53:49], zero fill[55:54]
    output logic      [esc_pkg::OUT_W-1:0]   m_tdata
);

    esc_pkg::esc_cmd_t  cmd;
    esc_pkg::esc_stat_t stat;

    esc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    esc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

// ----- src/esc_checker.sv -----
// port level checks of the epoch seconds to calendar converter, bound to the top
// depends on esc_pkg and epoch_seconds_to_calendar_assert.svh
`default_nettype none

`include "epoch_seconds_to_calendar_assert.svh"

module esc_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        cfg_wr_en,
    input wire logic [esc_pkg::YEAR_W-1:0]  cfg_wr_data,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic [esc_pkg::IN_W-1:0]    s_tdata,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [esc_pkg::OUT_W-1:0]   m_tdata
);

    logic [4:0] hour_f;
    logic [5:0] minute_f;
    logic [5:0] second_f;
    logic [3:0] month_f;
    logic [4:0] day_f;
    logic       s_req;
    logic       unused_ok;

    assign hour_f   = m_tdata[20:16];
    assign minute_f = m_tdata[26:21];
    assign second_f = m_tdata[32:27];
    assign month_f  = m_tdata[48:45];
    assign day_f    = m_tdata[53:49];
    assign s_req    = s_tvalid && s_tready;
    assign unused_ok = cfg_wr_en ^ (^cfg_wr_data) ^ (^s_tdata);

    // a stalled result holds
    `ESC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))

    // one request in flight: busy right after a request
    `ESC_ASSERT_NEXT(a_busy_after_req, clk, rst_n, s_req, !s_tready && !$rose(m_tvalid))

    // time of day fields in range
    `ESC_ASSERT_NOW(a_time_range, clk, rst_n, m_tvalid,
        hour_f <= 5'd23 && minute_f <= 6'd59 && second_f <= 6'd59)

    // date fields in range: month from 1 to 12, day at least 1
    `ESC_ASSERT_NOW(a_date_range, clk, rst_n, m_tvalid,
        month_f >= 4'd1 && month_f <= 4'd12 && day_f >= 5'd1 && (unused_ok || !unused_ok))

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (.*);

`default_nettype wire
